// ===== hdl/sorted_key_index_map_macros.svh =====
// assertion macros for the sorted key index map
// used by the top level only; no other dependencies
`ifndef SORTED_KEY_INDEX_MAP_MACROS_SVH
`define SORTED_KEY_INDEX_MAP_MACROS_SVH

// property holds in the same cycle
`define SKIM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SKIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/skim_pkg.sv =====
// shared types and constants for the sorted key index map
// no dependencies
`timescale 1ns / 1ps

package skim_pkg;

  localparam int unsigned ENTRIES_DEF = 64;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned SLOT_W      = 6;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_SHRD,
    ST_SHWR,
    ST_PUT,
    ST_DONE
  } state_e;

  typedef struct packed {
    cmd_e                    command;
    logic signed [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

// ===== hdl/skim_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module skim_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/skim_engine.sv =====
// search and shift sequencer over the key/slot table memory
// depends on skim_pkg and skim_ram
`timescale 1ns / 1ps

module skim_engine #(
  parameter int unsigned Entries = skim_pkg::ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  skim_pkg::in_t    req_i,
  output logic             req_ready_o,
  output skim_pkg::res_t   res_o,
  input  logic             res_take_i
);

  localparam int unsigned IDX_W  = $clog2(Entries);
  localparam int unsigned CNT_W  = $clog2(Entries + 1);
  localparam int unsigned WORD_W = skim_pkg::KEY_W + skim_pkg::SLOT_W;

  skim_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  skim_pkg::cmd_e   cmd_q, cmd_d;
  logic signed [skim_pkg::KEY_W-1:0] key_q, key_d;
  skim_pkg::out_t   out_q, out_d;

  logic [CNT_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic [CNT_W-1:0]    ptr_m1;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  logic signed [skim_pkg::KEY_W-1:0] rd_key;
  logic [skim_pkg::SLOT_W-1:0]       rd_slot;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - (CNT_W + 1)'(1);
  assign mid     = mid_sum[IDX_W:1];
  assign ptr_m1  = ptr_q - CNT_W'(1);
  assign rd_key  = $signed(ram_rdata[WORD_W-1:skim_pkg::SLOT_W]);
  assign rd_slot = ram_rdata[skim_pkg::SLOT_W-1:0];

  skim_ram #(
    .Width (WORD_W),
    .Depth (Entries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= skim_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    ptr_q <= ptr_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    ptr_d       = ptr_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    out_d       = out_q;
    req_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = ptr_q[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = mid;

    unique case (state_q)
      skim_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_d = req_i.command;
          key_d = req_i.key;
          lo_d  = '0;
          hi_d  = count_q;
          ptr_d = count_q;
          if (req_i.command == skim_pkg::CMD_INSERT && count_q == CNT_W'(Entries)) begin
            out_d   = '{slot: '0, status: skim_pkg::STATUS_FULL};
            state_d = skim_pkg::ST_DONE;
          end else begin
            state_d = skim_pkg::ST_SRCH;
          end
        end
      end
      skim_pkg::ST_SRCH: begin
        if (lo_q < hi_q) begin
          state_d = skim_pkg::ST_CMP;
        end else if (cmd_q == skim_pkg::CMD_INSERT) begin
          state_d = skim_pkg::ST_SHRD;
        end else begin
          out_d   = '{slot: '0, status: skim_pkg::STATUS_MISSING};
          state_d = skim_pkg::ST_DONE;
        end
      end
      skim_pkg::ST_CMP: begin
        state_d = skim_pkg::ST_SRCH;
        if (key_q < rd_key) begin
          hi_d = CNT_W'(mid);
        end else if (cmd_q == skim_pkg::CMD_LOOKUP && key_q == rd_key) begin
          out_d   = '{slot: rd_slot, status: skim_pkg::STATUS_OK};
          state_d = skim_pkg::ST_DONE;
        end else begin
          lo_d = CNT_W'(mid) + CNT_W'(1);
        end
      end
      skim_pkg::ST_SHRD: begin
        ram_raddr = ptr_m1[IDX_W-1:0];
        if (ptr_q > lo_q) begin
          state_d = skim_pkg::ST_SHWR;
        end else begin
          state_d = skim_pkg::ST_PUT;
        end
      end
      skim_pkg::ST_SHWR: begin
        ram_we  = 1'b1;
        ptr_d   = ptr_m1;
        state_d = skim_pkg::ST_SHRD;
      end
      skim_pkg::ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lo_q[IDX_W-1:0];
        ram_wdata = {key_q, skim_pkg::SLOT_W'(count_q)};
        out_d     = '{slot: skim_pkg::SLOT_W'(count_q), status: skim_pkg::STATUS_OK};
        count_d   = count_q + CNT_W'(1);
        state_d   = skim_pkg::ST_DONE;
      end
      skim_pkg::ST_DONE: begin
        if (res_take_i) begin
          state_d = skim_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = skim_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = '{valid: (state_q == skim_pkg::ST_DONE), data: out_q};

endmodule

// ===== hdl/sorted_key_index_map.sv =====
// one transfer at a time; the next transfer is taken once the result leaves the engine for
// the output register
// reset: entry count clears to zero, table contents stay undefined until written
// depends on skim_pkg, skim_engine and sorted_key_index_map_macros.svh
`timescale 1ns / 1ps
`include "sorted_key_index_map_macros.svh"

module sorted_key_index_map #(
  parameter int unsigned Entries = skim_pkg::ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  skim_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output skim_pkg::out_t  out_data_o
);

  skim_pkg::res_t res;
  logic           take;
  logic           out_valid_q, out_valid_d;
  skim_pkg::out_t out_data_q;

  skim_engine #(
    .Entries (Entries)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (in_data_i),
    .req_ready_o (in_ready_o),
    .res_o       (res),
    .res_take_i  (take)
  );

  // output register frees the engine while a result waits
  assign take        = res.valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = take || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `SKIM_ASSERT(a_busy_with_result, clk_i, rst_ni, !(res.valid && in_ready_o), "accepting while result pending")
  `SKIM_ASSERT_NEXT(a_take_fills_out, clk_i, rst_ni, take, out_valid_o, "result transfer lost")
  `SKIM_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "engine not busy after transfer")

endmodule
